FILE: rtl/avm_pkg.sv
package avm_pkg;

  localparam int unsigned CODE_W  = 10;
  localparam int unsigned MS_W    = 15;
  localparam int unsigned SKIP_W  = 5;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned AVGN_W  = 4;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned AVG_SAMPLES_DEF = 10;
  localparam int unsigned TICK_MS_DEF     = 5;
  localparam int unsigned PRE_PULSE_MS    = 200;

  localparam logic [CODE_W-1:0] CURRENT_ON_RST = CODE_W'(102);
  localparam logic [CODE_W-1:0] SHORT_TH_RST   = CODE_W'(50);
  localparam logic [CODE_W-1:0] WINDOW_LOW_RST = CODE_W'(23);
  localparam logic [CODE_W-1:0] WINDOW_HIGH_RST = CODE_W'(839);
  localparam logic [SKIP_W-1:0] SKIP_RST       = SKIP_W'(20);
  localparam logic [WAIT_W-1:0] SPARK_WAIT_RST = WAIT_W'(200);

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_ON  = 3'd0,
    REG_SHORT_TH    = 3'd1,
    REG_WINDOW_LOW  = 3'd2,
    REG_WINDOW_HIGH = 3'd3,
    REG_SKIP        = 3'd4,
    REG_SPARK_WAIT  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              opcode;
    logic [CODE_W-1:0] voltage_code;
    logic [CODE_W-1:0] current_code;
    logic [MS_W-1:0]   pulse_ms;
  } in_word_t;

  typedef struct packed {
    logic              torch_on;
    logic              short_valid;
    logic [CODE_W-1:0] short_code;
    logic              report_valid;
    logic [CODE_W-1:0] report_value;
  } out_word_t;

endpackage

FILE: rtl/avm_ifs.sv
interface avm_in_if;
  logic               valid;
  logic               ready;
  avm_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface avm_out_if;
  logic               valid;
  logic               ready;
  avm_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/avm_cdiv.sv
// Unsigned divide by a constant: multiply by the rounded-up reciprocal and shift.
// Exact for every NUM_W-bit numerator (shift = NUM_W + ceil(log2 DIVISOR)).
module avm_cdiv #(
  parameter int unsigned NUM_W   = 15,
  parameter int unsigned DIVISOR = 5
) (
  input  logic [NUM_W-1:0] num,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned SHIFT  = NUM_W + $clog2(DIVISOR);
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned MULT_W = SHIFT + 1;
  localparam int unsigned PROD_W = NUM_W + MULT_W;

  logic [MULT_W-1:0] mult;
  logic [PROD_W-1:0] prod;

  assign mult = MULT_W'(MULT);
  assign prod = PROD_W'(num) * PROD_W'(mult);
  assign quo  = prod[SHIFT +: NUM_W];

endmodule

FILE: rtl/arc_voltage_monitor_pulse_timer.sv
// Arc voltage monitor and pulse timer for a TIG torch. Each input word is either a
// measurement tick (opcode 0, one per TICK_MS ms: voltage and current converter codes)
// or a pulse start (opcode 1, pulse length in ms; zero is ignored). A tick first
// advances the pulse timer using the arc flag from the previous tick, then checks
// for a short (voltage below short_threshold: pulse cancelled, torch off, raw code
// reported), then updates the arc flag from the current. While the arc is on,
// in-window voltage codes are skipped skip_samples times and the next AVG_SAMPLES
// are summed; at arc end the truncated mean is reported if the set was full and the
// mean sits inside the window. Every input word gives exactly one result word.
// Rate: one word per clock sustained while results.ready is high; a word passes the
// input register, then the result register, with the single-pass timer and averager
// state update between them. The result register decouples the output side, so a new
// word is taken while a finished result still waits. Configuration registers are
// written through cfg_we/cfg_index/cfg_data; indices 6 and 7 are ignored.
module arc_voltage_monitor_pulse_timer #(
  parameter int unsigned AVG_SAMPLES = avm_pkg::AVG_SAMPLES_DEF,
  parameter int unsigned TICK_MS     = avm_pkg::TICK_MS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  avm_in_if.sink                           samples,
  avm_out_if.source                        results,
  input  logic                             cfg_we,
  input  logic [avm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [avm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned CODE_W  = avm_pkg::CODE_W;
  localparam int unsigned COUNT_W = avm_pkg::COUNT_W;
  localparam int unsigned SKIP_W  = avm_pkg::SKIP_W;
  localparam int unsigned WAIT_W  = avm_pkg::WAIT_W;
  localparam int unsigned AVGN_W  = avm_pkg::AVGN_W;
  localparam int unsigned SUM_W   = avm_pkg::SUM_W;
  localparam int unsigned MS_W    = avm_pkg::MS_W;

  // pulse end after reset: spark wait plus the fixed pre-pulse length in ticks
  localparam int unsigned END_RST_INT =
    int'(avm_pkg::SPARK_WAIT_RST) + avm_pkg::PRE_PULSE_MS / TICK_MS;
  localparam logic [COUNT_W-1:0] PULSE_END_RST = COUNT_W'(END_RST_INT);
  localparam logic [AVGN_W-1:0]  AVG_N = AVGN_W'(AVG_SAMPLES);

  // config registers
  logic [CODE_W-1:0] current_on_threshold;
  logic [CODE_W-1:0] short_threshold;
  logic [CODE_W-1:0] window_low;
  logic [CODE_W-1:0] window_high;
  logic [SKIP_W-1:0] skip_samples;
  logic [WAIT_W-1:0] spark_wait_ticks;

  // block state
  logic               pulse_active, pulse_active_next;
  logic [COUNT_W-1:0] pulse_count, pulse_count_next;
  logic [COUNT_W-1:0] pulse_end, pulse_end_next;
  logic               arc_on, arc_on_next;
  logic [SKIP_W-1:0]  skip_left, skip_left_next;
  logic [AVGN_W-1:0]  avg_count, avg_count_next;
  logic [SUM_W-1:0]   avg_sum, avg_sum_next;
  logic               torch_state, torch_state_next;

  // handshake / pipeline
  logic               s1_valid;
  avm_pkg::in_word_t  s1_word;
  logic               out_valid;
  avm_pkg::out_word_t out_word;
  avm_pkg::out_word_t res;
  logic               out_free;
  logic               s1_fire;
  logic               in_fire;

  // divide-by-constant units
  logic [MS_W-1:0]  ms_ticks;
  logic [SUM_W-1:0] mean;

  logic [COUNT_W-1:0] spark_ext;
  logic               in_window;

  // no word is taken while in reset
  assign out_free      = !out_valid || results.ready;
  assign s1_fire       = s1_valid && out_free;
  assign samples.ready = !rst && (!s1_valid || out_free);
  assign in_fire       = samples.valid && samples.ready;
  assign results.valid = out_valid;
  assign results.data  = out_word;

  avm_cdiv #(.NUM_W(MS_W), .DIVISOR(TICK_MS)) u_ms_div (
    .num (s1_word.pulse_ms),
    .quo (ms_ticks)
  );

  avm_cdiv #(.NUM_W(SUM_W), .DIVISOR(AVG_SAMPLES)) u_mean_div (
    .num (avg_sum),
    .quo (mean)
  );

  assign spark_ext = COUNT_W'(spark_wait_ticks);
  assign in_window = (s1_word.voltage_code > window_low) &&
                     (s1_word.voltage_code < window_high);

  // single-pass state update for the word in the input register
  always_comb begin
    logic [COUNT_W-1:0] cnt;
    logic [SUM_W-1:0]   mean_ok_cmp;
    pulse_active_next = pulse_active;
    pulse_count_next  = pulse_count;
    pulse_end_next    = pulse_end;
    arc_on_next       = arc_on;
    skip_left_next    = skip_left;
    avg_count_next    = avg_count;
    avg_sum_next      = avg_sum;
    torch_state_next  = torch_state;
    res               = '0;
    cnt               = pulse_count;
    mean_ok_cmp       = mean;

    if (s1_word.opcode == avm_pkg::OP_START) begin
      if (s1_word.pulse_ms != '0) begin
        pulse_count_next  = '0;
        pulse_end_next    = COUNT_W'(spark_ext + COUNT_W'(ms_ticks));
        pulse_active_next = 1'b1;
      end
    end else begin
      // timer advance, uses last tick's arc flag
      if (pulse_active) begin
        if (pulse_count == '0) begin
          torch_state_next = 1'b1;
        end
        if (pulse_count == pulse_end) begin
          torch_state_next  = 1'b0;
          pulse_active_next = 1'b0;
          cnt = '0;
        end else begin
          cnt = COUNT_W'(pulse_count + COUNT_W'(1));
        end
        if (arc_on && (cnt < spark_ext)) begin
          cnt = spark_ext;
        end
        if (!arc_on && (cnt >= spark_ext)) begin
          cnt = pulse_end;
        end
        pulse_count_next = cnt;
      end

      // short circuit cancels the pulse
      if (s1_word.voltage_code < short_threshold) begin
        pulse_active_next = 1'b0;
        torch_state_next  = 1'b0;
        pulse_count_next  = '0;
        res.short_valid   = 1'b1;
        res.short_code    = s1_word.voltage_code;
      end

      if (s1_word.current_code > current_on_threshold) begin
        arc_on_next = 1'b1;
        if (in_window) begin
          if ((skip_left == '0) && (avg_count < AVG_N)) begin
            avg_sum_next   = SUM_W'(avg_sum + SUM_W'(s1_word.voltage_code));
            avg_count_next = AVGN_W'(avg_count + AVGN_W'(1));
          end else if (skip_left != '0) begin
            skip_left_next = SKIP_W'(skip_left - SKIP_W'(1));
          end
        end
      end else if (arc_on) begin
        // arc end: report a full, in-window mean, then rearm the averager
        arc_on_next = 1'b0;
        if ((avg_count == AVG_N) &&
            (mean_ok_cmp > SUM_W'(window_low)) &&
            (mean_ok_cmp < SUM_W'(window_high))) begin
          res.report_valid = 1'b1;
          res.report_value = mean[CODE_W-1:0];
        end
        avg_sum_next   = '0;
        avg_count_next = '0;
        skip_left_next = skip_samples;
      end
    end

    res.torch_on = torch_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word <= samples.data;
    end
    if (s1_fire) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_active <= 1'b0;
      pulse_count  <= '0;
      pulse_end    <= PULSE_END_RST;
      arc_on       <= 1'b0;
      skip_left    <= avm_pkg::SKIP_RST;
      avg_count    <= '0;
      avg_sum      <= '0;
      torch_state  <= 1'b0;
    end else if (s1_fire) begin
      pulse_active <= pulse_active_next;
      pulse_count  <= pulse_count_next;
      pulse_end    <= pulse_end_next;
      arc_on       <= arc_on_next;
      skip_left    <= skip_left_next;
      avg_count    <= avg_count_next;
      avg_sum      <= avg_sum_next;
      torch_state  <= torch_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_on_threshold <= avm_pkg::CURRENT_ON_RST;
      short_threshold      <= avm_pkg::SHORT_TH_RST;
      window_low           <= avm_pkg::WINDOW_LOW_RST;
      window_high          <= avm_pkg::WINDOW_HIGH_RST;
      skip_samples         <= avm_pkg::SKIP_RST;
      spark_wait_ticks     <= avm_pkg::SPARK_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        avm_pkg::REG_CURRENT_ON:  current_on_threshold <= cfg_data[CODE_W-1:0];
        avm_pkg::REG_SHORT_TH:    short_threshold      <= cfg_data[CODE_W-1:0];
        avm_pkg::REG_WINDOW_LOW:  window_low           <= cfg_data[CODE_W-1:0];
        avm_pkg::REG_WINDOW_HIGH: window_high          <= cfg_data[CODE_W-1:0];
        avm_pkg::REG_SKIP:        skip_samples         <= cfg_data[SKIP_W-1:0];
        avm_pkg::REG_SPARK_WAIT:  spark_wait_ticks     <= cfg_data[WAIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // torch is only ever on inside a running pulse
  a_torch_in_pulse: assert property (@(posedge clk) disable iff (rst)
    torch_state |-> pulse_active)
    else $error("torch on without an active pulse");

  // averager never overfills
  a_avg_bound: assert property (@(posedge clk) disable iff (rst)
    avg_count <= AVG_N)
    else $error("average count above sample limit");

  // no sample is summed while skipping is still pending
  a_skip_before_sum: assert property (@(posedge clk) disable iff (rst)
    (skip_left != '0) |-> (avg_count == '0))
    else $error("samples summed before skip finished");

  // a pending report word means the arc has ended
  a_report_arc_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.report_valid) |-> !arc_on)
    else $error("report pending while arc still on");

  // a short always leaves the torch off in the same word
  a_short_torch_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.short_valid) |-> !out_word.torch_on)
    else $error("short reported with torch on");

endmodule
